// ===== rtl/sip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg: shared types, constants and round function for the SipHash engine
// Lane bundle, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int unsigned WORD_W    = 64;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned LEN_W     = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'd1;

   localparam logic [WORD_W-1:0] INIT_A         = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_B         = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_C         = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_D         = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] KEY_LOW_RESET  = 64'h0706050403020100;
   localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
   localparam logic [WORD_W-1:0] FINAL_XOR      = 64'h00000000000000ff;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } sip_lanes_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // take the input item, d ^= its first block
      logic init;     // reload lanes from key (first word of a message)
      logic round;    // one SipRound
      logic mix_a;    // a ^= current block
      logic add_pad;  // d ^= length-only block of a full last word
      logic fin;      // c ^= 0xff
      logic emit;     // capture hash into output register
   } sip_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_last;  // item is the last word
      logic in_full;  // item carries 8 or more bytes
   } sip_status_type;

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                input int unsigned r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic sip_lanes_type sip_round(input sip_lanes_type s);
      sip_lanes_type t;
      t = s;
      t.a = t.a + t.b;
      t.b = rotl64(t.b, 13) ^ t.a;
      t.a = rotl64(t.a, 32);
      t.c = t.c + t.d;
      t.d = rotl64(t.d, 16) ^ t.c;
      t.a = t.a + t.d;
      t.d = rotl64(t.d, 21) ^ t.a;
      t.c = t.c + t.b;
      t.b = rotl64(t.b, 17) ^ t.c;
      t.c = rotl64(t.c, 32);
      return t;
   endfunction

endpackage

// ===== rtl/siphash_2_4_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_engine: keyed SipHash-2-4 over a stream of 64-bit words
// Timing: one SipRound per cycle; rate is set by the single round unit. The
//   hash shows once the finalization rounds end and the output is free.
// Throughput: the next word of a message is taken on the second round of a
//   non-last word; after a last word, only once the hash has been emitted.
// Reset: key returns to 0x0706..00 / 0x0f0e..08, no message open, no result.
// ----------------------------------------------------------------------------
module siphash_2_4_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration: index 0 = key_low, 1 = key_high
   input  logic                                 csr_write_enable,
   input  logic [sip_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sip_pkg::WORD_W-1:0]           csr_write_data,
   // message words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sip_pkg::WORD_W-1:0]           req_msg_word,
   input  logic [sip_pkg::COUNT_W-1:0]          req_valid_bytes,
   input  logic                                 req_last_word,
   // hash results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sip_pkg::WORD_W-1:0]           rsp_hash_value
);

   // The sequencer walks each item through:
   //   accept   - lanes load from the key on the first word, d ^= block
   //   2 rounds - compression; second round also does a ^= block
   //   full last word only: 2 more rounds for the length-only block
   //   c ^= 0xff folded into the last compression round, then 4 rounds
   //   emit     - XOR of lanes into the output register
   // The next word of a message is taken on the second compression round,
   // so a stream of full words runs back to back.
   // The output register lets a new message start while a hash waits.

   sip_pkg::sip_cmd_type    cmd;
   sip_pkg::sip_status_type status;

   sip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sip_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_msg_word     (req_msg_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_last_word    (req_last_word),
      .cmd              (cmd),
      .status           (status),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

// ===== rtl/sip_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_dp: SipHash datapath
// Key registers, four lanes with one SipRound per cycle, block and length
// registers, output hash register.
// ----------------------------------------------------------------------------
module sip_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sip_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sip_pkg::WORD_W-1:0]           csr_write_data,
   input  logic [sip_pkg::WORD_W-1:0]           req_msg_word,
   input  logic [sip_pkg::COUNT_W-1:0]          req_valid_bytes,
   input  logic                                 req_last_word,
   input  sip_pkg::sip_cmd_type                 cmd,
   output sip_pkg::sip_status_type              status,
   output logic [sip_pkg::WORD_W-1:0]           rsp_hash_value
);

   logic [sip_pkg::WORD_W-1:0] key_low_ff;
   logic [sip_pkg::WORD_W-1:0] key_high_ff;
   sip_pkg::sip_lanes_type     lanes_ff, lanes_in;
   sip_pkg::sip_lanes_type     rnd, base;
   logic [sip_pkg::WORD_W-1:0] blk_ff, blk_in;
   logic [sip_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [sip_pkg::WORD_W-1:0] hash_ff;
   logic [sip_pkg::WORD_W-1:0] pad;
   logic [sip_pkg::WORD_W-1:0] blk0;
   logic [sip_pkg::WORD_W-1:0] byte_mask;
   logic [sip_pkg::COUNT_W-1:0] add_cnt;
   logic [sip_pkg::LEN_W-1:0]  len_new;
   logic                       in_full;

   assign in_full = req_valid_bytes[sip_pkg::COUNT_W-1];  // 8..15 -> full word
   assign status.in_last = req_last_word;
   assign status.in_full = in_full;

   // length so far, counting this item
   always_comb begin
      if (!req_last_word || in_full) begin
         add_cnt = 4'd8;
      end else begin
         add_cnt = {1'b0, req_valid_bytes[2:0]};
      end
      len_new = (cmd.init ? '0 : len_ff) + {4'd0, add_cnt};
   end

   // keep bytes below the count on a short last word
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = (3'(i) < req_valid_bytes[2:0]) ? 8'hff : 8'h00;
      end
      if (req_last_word && !in_full) begin
         blk0 = (req_msg_word & byte_mask) | {len_new, 56'd0};
      end else begin
         blk0 = req_msg_word;
      end
   end

   assign pad = {len_ff, 56'd0};
   assign rnd = sip_pkg::sip_round(lanes_ff);

   always_comb begin
      base = cmd.round ? rnd : lanes_ff;
      if (cmd.init) begin
         base.a = sip_pkg::INIT_A ^ key_low_ff;
         base.b = sip_pkg::INIT_B ^ key_high_ff;
         base.c = sip_pkg::INIT_C ^ key_low_ff;
         base.d = sip_pkg::INIT_D ^ key_high_ff;
      end
      lanes_in.a = base.a ^ (cmd.mix_a ? blk_ff : '0);
      lanes_in.b = base.b;
      lanes_in.c = base.c ^ (cmd.fin ? sip_pkg::FINAL_XOR : '0);
      lanes_in.d = base.d ^ (cmd.load ? blk0 : '0) ^ (cmd.add_pad ? pad : '0);

      blk_in = blk_ff;
      len_in = len_ff;
      if (cmd.load) begin
         blk_in = blk0;
         len_in = len_new;
      end else if (cmd.add_pad) begin
         blk_in = pad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= sip_pkg::KEY_LOW_RESET;
         key_high_ff <= sip_pkg::KEY_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sip_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            sip_pkg::CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      blk_ff   <= blk_in;
      len_ff   <= len_in;
      if (cmd.emit) begin
         hash_ff <= lanes_ff.a ^ lanes_ff.b ^ lanes_ff.c ^ lanes_ff.d;
      end
   end

   assign rsp_hash_value = hash_ff;

endmodule

// ===== rtl/sip_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_ctrl: SipHash sequencer
// Steps compression and finalization rounds, owns the handshakes.
// ----------------------------------------------------------------------------
module sip_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sip_pkg::sip_status_type  status,
   output sip_pkg::sip_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_FINAL,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       full_ff, full_in;
   logic       open_ff, open_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   // open for a new item when idle, or on the second round of a non-last word
   assign req_stall = !((state_ff == ST_IDLE) ||
                        (state_ff == ST_ABSORB && cnt_ff == 2'd1 && !last_ff));
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;

      if (accept) begin
         cmd.load = 1'b1;
         cmd.init = !open_ff;
         open_in  = 1'b1;
         last_in  = status.in_last;
         full_in  = status.in_full;
         state_in = ST_ABSORB;
         cnt_in   = 2'd0;
      end

      case (state_ff)
         ST_IDLE: ;
         ST_ABSORB: begin
            cmd.round = 1'b1;
            if (cnt_ff == 2'd0) begin
               cnt_in = 2'd1;
            end else begin
               cmd.mix_a = 1'b1;
               if (!last_ff) begin
                  if (!accept) begin
                     state_in = ST_IDLE;
                  end
               end else if (full_ff) begin
                  // full last word: absorb the length-only block next
                  cmd.add_pad = 1'b1;
                  full_in     = 1'b0;
                  cnt_in      = 2'd0;
               end else begin
                  cmd.fin  = 1'b1;
                  state_in = ST_FINAL;
                  cnt_in   = 2'd0;
               end
            end
         end
         ST_FINAL: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               open_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 2'd0;
         last_ff      <= 1'b0;
         full_ff      <= 1'b0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         full_ff      <= full_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
